>>> rtl/nitp_pkg.sv
// ----------------------------------------------------------------------------
// Nested IRQ time profiler package
// Sizes, codes, storage layouts and state types shared by the profiler files.
// ----------------------------------------------------------------------------
package nitp_pkg;

  localparam int CPU_COUNT     = 4;
  localparam int STACK_DEPTH   = 16;
  localparam int IRQ_COUNT     = 512;
  localparam int SLOTS_PER_IRQ = 4;

  localparam int IRQ_W   = 16;
  localparam int DEV_W   = 32;
  localparam int TIME_W  = 64;
  localparam int COUNT_W = 32;

  localparam int FRAMES    = CPU_COUNT * STACK_DEPTH;
  localparam int ROWS      = CPU_COUNT * IRQ_COUNT;
  localparam int SLOTS_ALL = ROWS * SLOTS_PER_IRQ;

  localparam int CPU_W = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
  localparam int TOP_W = $clog2(STACK_DEPTH + 1);
  localparam int FA_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int RA_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int SA_W  = (SLOTS_ALL > 1) ? $clog2(SLOTS_ALL) : 1;
  localparam int SI_W  = $clog2(SLOTS_PER_IRQ + 1);
  localparam int SL_W  = (SLOTS_PER_IRQ > 1) ? $clog2(SLOTS_PER_IRQ) : 1;

  localparam logic KIND_ENTRY = 1'b0;
  localparam logic KIND_EXIT  = 1'b1;

  typedef enum logic [2:0] {
    ST_ENTRY      = 3'd0,
    ST_EXIT       = 3'd1,
    ST_IRQ_RANGE  = 3'd2,
    ST_FULL       = 3'd3,
    ST_EMPTY      = 3'd4,
    ST_MISMATCH   = 3'd5,
    ST_TABLE_FULL = 3'd6
  } status_e;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_PRD,
    S_PSUB,
    S_PADD,
    S_PUSH,
    S_FRD,
    S_FSUB,
    S_FADD,
    S_WALK,
    S_CMP,
    S_POP,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [IRQ_W-1:0] irq;
    logic [DEV_W-1:0] device;
  } frame_id_t;

  typedef struct packed {
    logic [DEV_W-1:0]   device;
    logic [TIME_W-1:0]  total;
    logic [COUNT_W-1:0] count;
  } slot_t;

endpackage

>>> rtl/nested_irq_time_profiler_unit.sv
// ----------------------------------------------------------------------------
// Nested IRQ time profiler
// Per-CPU handler nesting stacks and a per-(CPU, IRQ, device) time table.
// ----------------------------------------------------------------------------
// Usage: an event (entry or exit of an interrupt handler) is transferred at a
// rising clock edge with start_i high and busy_o low. Exactly one result
// follows per event; it is shown for a single cycle with done_o high and the
// receiver must take it then, since it cannot hold results off.
// Steps after the transfer: a rejected event (irq out of range, stack full,
// stack empty) goes straight to the result; an entry on an empty stack
// pushes its frame; an entry that charges a parent reads the parent frame,
// subtracts, adds into its total and then pushes. An exit reads the top
// frame and subtracts, and answers on an IRQ mismatch; otherwise it adds,
// walks the occupied slots of that IRQ one at a time, reading then comparing
// each, until it claims a free slot, finds the row full (all SLOTS_PER_IRQ
// slots held by other devices) or hits the device, and pops the frame.
// The next event is taken in the cycle after done_o. The work is paced by
// the single shared 64-bit adder, used by every time update, and the walk.
// Reset: the stacks are emptied at once, then a clearing pass writes the slot
// valid memory one row per cycle over all CPU_COUNT * IRQ_COUNT rows (2048
// here), with busy_o held high.
// ----------------------------------------------------------------------------
module nested_irq_time_profiler_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        kind_i,
  input  logic [1:0]  cpu_index_i,
  input  logic [15:0] irq_number_i,
  input  logic [31:0] device_tag_i,
  input  logic [63:0] timestamp_ns_i,
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic [15:0] irq_out_o,
  output logic [63:0] last_run_time_o,
  output logic [63:0] slot_total_o,
  output logic [31:0] event_count_o
);
  import nitp_pkg::*;

  // Sequencer state and the housekeeping counters.
  state_e state_q, state_d;
  logic [RA_W-1:0] clr_q, clr_d;
  logic [SI_W-1:0] slot_i_q, slot_i_d;

  // The nesting depth of every CPU lives in flip-flops.
  logic [TOP_W-1:0] stack_top_q [CPU_COUNT];
  logic [TOP_W-1:0] stack_top_d [CPU_COUNT];

  // Event captured at the transfer.
  logic [CPU_W-1:0]   cpu_q, cpu_d;
  logic [IRQ_W-1:0]   irq_q, irq_d;
  logic [DEV_W-1:0]   dev_q, dev_d;
  logic [TIME_W-1:0]  now_q, now_d;
  logic [TOP_W-1:0]   top_q, top_d;

  // Intermediate times.
  logic [TIME_W-1:0]  run_q, run_d;
  logic [TIME_W-1:0]  excl_q, excl_d;

  // Result registers.
  status_e            status_q, status_d;
  logic [TIME_W-1:0]  run_res_q, run_res_d;
  logic [TIME_W-1:0]  total_res_q, total_res_d;
  logic [COUNT_W-1:0] count_res_q, count_res_d;

  // Decoded view of the incoming event.
  logic [CPU_W-1:0] cpu_in;
  logic [TOP_W-1:0] top_in;
  logic             irq_bad;
  logic             accept;

  // Addresses derived from the captured event.
  logic [FA_W-1:0] f_top;
  logic [FA_W-1:0] f_new;
  logic [FA_W-1:0] f_parent;
  logic [RA_W-1:0] row_addr;
  logic [SA_W-1:0] slot_addr;
  logic [SL_W-1:0] slot_sel;
  logic            walk_end;
  logic            clr_last;

  // Memory ports.
  logic                  fid_we;
  frame_id_t             fid_wdata;
  frame_id_t             fid_rd;
  logic [2*IRQ_W+DEV_W-IRQ_W-1:0] fid_rdata;
  logic                  fid_re;

  logic                  start_we;
  logic [FA_W-1:0]       start_waddr;
  logic [TIME_W-1:0]     start_wdata;
  logic [TIME_W-1:0]     start_rdata;
  logic                  frame_re;

  logic                  accum_we;
  logic [FA_W-1:0]       accum_waddr;
  logic [TIME_W-1:0]     accum_wdata;
  logic [TIME_W-1:0]     accum_rdata;

  logic                    valid_we;
  logic [RA_W-1:0]         valid_waddr;
  logic [SLOTS_PER_IRQ-1:0] valid_wdata;
  logic                    valid_re;
  logic [SLOTS_PER_IRQ-1:0] valid_rdata;

  logic        slot_we;
  slot_t       slot_wdata;
  logic        slot_re;
  slot_t       slot_rd;
  logic [$bits(slot_t)-1:0] slot_rdata;

  // Shared adder.
  alu_op_e           alu_op;
  logic [TIME_W-1:0] alu_a;
  logic [TIME_W-1:0] alu_b;
  logic [TIME_W-1:0] alu_y;

  logic [COUNT_W-1:0] count_next;

  assign cpu_in  = CPU_W'(cpu_index_i % CPU_COUNT);
  assign top_in  = stack_top_q[cpu_in];
  assign irq_bad = irq_number_i >= IRQ_W'(IRQ_COUNT);
  assign accept  = start_i && (state_q == S_IDLE);

  // Frame addresses: the top frame, the slot for a new frame and the parent
  // of the top frame. The parent address is only used when it exists.
  assign f_new     = FA_W'(cpu_q) * FA_W'(STACK_DEPTH) + FA_W'(top_q);
  assign f_top     = f_new - FA_W'(1);
  assign f_parent  = f_top - FA_W'(1);
  assign row_addr  = RA_W'(cpu_q) * RA_W'(IRQ_COUNT) + RA_W'(irq_q);
  assign slot_addr = SA_W'(row_addr) * SA_W'(SLOTS_PER_IRQ) + SA_W'(slot_i_q);
  assign slot_sel  = slot_i_q[SL_W-1:0];
  assign walk_end  = slot_i_q == SI_W'(SLOTS_PER_IRQ);
  assign clr_last  = clr_q == RA_W'(ROWS - 1);

  assign fid_rd  = fid_rdata;
  assign slot_rd = slot_rdata;

  assign count_next = (slot_rd.count == {COUNT_W{1'b1}}) ? slot_rd.count
                                                         : slot_rd.count + COUNT_W'(1);

  nitp_ram #(
    .WIDTH ($bits(frame_id_t)),
    .DEPTH (FRAMES)
  ) u_frame_id_ram (
    .clk_i   (clk_i),
    .we_i    (fid_we),
    .waddr_i (f_new),
    .wdata_i (fid_wdata),
    .re_i    (fid_re),
    .raddr_i (f_top),
    .rdata_o (fid_rdata)
  );

  nitp_ram #(
    .WIDTH (TIME_W),
    .DEPTH (FRAMES)
  ) u_frame_start_ram (
    .clk_i   (clk_i),
    .we_i    (start_we),
    .waddr_i (start_waddr),
    .wdata_i (start_wdata),
    .re_i    (frame_re),
    .raddr_i (f_top),
    .rdata_o (start_rdata)
  );

  nitp_ram #(
    .WIDTH (TIME_W),
    .DEPTH (FRAMES)
  ) u_frame_accum_ram (
    .clk_i   (clk_i),
    .we_i    (accum_we),
    .waddr_i (accum_waddr),
    .wdata_i (accum_wdata),
    .re_i    (frame_re),
    .raddr_i (f_top),
    .rdata_o (accum_rdata)
  );

  nitp_ram #(
    .WIDTH (SLOTS_PER_IRQ),
    .DEPTH (ROWS)
  ) u_valid_ram (
    .clk_i   (clk_i),
    .we_i    (valid_we),
    .waddr_i (valid_waddr),
    .wdata_i (valid_wdata),
    .re_i    (valid_re),
    .raddr_i (row_addr),
    .rdata_o (valid_rdata)
  );

  nitp_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (SLOTS_ALL)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_addr),
    .wdata_i (slot_wdata),
    .re_i    (slot_re),
    .raddr_i (slot_addr),
    .rdata_o (slot_rdata)
  );

  nitp_alu u_alu (
    .op_i (alu_op),
    .a_i  (alu_a),
    .b_i  (alu_b),
    .y_o  (alu_y)
  );

  // Next-state logic of the sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          priority if (irq_bad) begin
            state_d = S_RESP;
          end else if (kind_i == KIND_ENTRY) begin
            priority if (top_in >= TOP_W'(STACK_DEPTH)) begin
              state_d = S_RESP;
            end else if (top_in == '0) begin
              state_d = S_PUSH;
            end else begin
              state_d = S_PRD;
            end
          end else if (top_in == '0) begin
            state_d = S_RESP;
          end else begin
            state_d = S_FRD;
          end
        end
      end
      S_PRD:  state_d = S_PSUB;
      S_PSUB: state_d = S_PADD;
      S_PADD: state_d = S_PUSH;
      S_PUSH: state_d = S_RESP;
      S_FRD:  state_d = S_FSUB;
      S_FSUB: begin
        if (fid_rd.irq != irq_q) begin
          state_d = S_RESP;
        end else begin
          state_d = S_FADD;
        end
      end
      S_FADD: state_d = S_WALK;
      S_WALK: begin
        priority if (walk_end) begin
          state_d = S_POP;
        end else if (!valid_rdata[slot_sel]) begin
          state_d = S_POP;
        end else begin
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        if (slot_rd.device == fid_rd.device) begin
          state_d = S_POP;
        end else begin
          state_d = S_WALK;
        end
      end
      S_POP:  state_d = S_RESP;
      S_RESP: state_d = S_IDLE;
      default: state_d = S_CLEAR;
    endcase
  end

  // Datapath control: memory ports, the shared adder and register updates.
  always_comb begin
    clr_d       = clr_q;
    slot_i_d    = slot_i_q;
    stack_top_d = stack_top_q;
    cpu_d       = cpu_q;
    irq_d       = irq_q;
    dev_d       = dev_q;
    now_d       = now_q;
    top_d       = top_q;
    run_d       = run_q;
    excl_d      = excl_q;
    status_d    = status_q;
    run_res_d   = run_res_q;
    total_res_d = total_res_q;
    count_res_d = count_res_q;

    fid_we      = 1'b0;
    fid_wdata   = '{irq: irq_q, device: dev_q};
    fid_re      = 1'b0;
    frame_re    = 1'b0;
    start_we    = 1'b0;
    start_waddr = f_new;
    start_wdata = now_q;
    accum_we    = 1'b0;
    accum_waddr = f_new;
    accum_wdata = '0;
    valid_we    = 1'b0;
    valid_waddr = row_addr;
    valid_wdata = valid_rdata;
    valid_re    = 1'b0;
    slot_we     = 1'b0;
    slot_wdata  = '{device: fid_rd.device, total: excl_q, count: COUNT_W'(1)};
    slot_re     = 1'b0;

    alu_op = ALU_ADD;
    alu_a  = accum_rdata;
    alu_b  = run_q;

    unique case (state_q)
      S_CLEAR: begin
        valid_we    = 1'b1;
        valid_waddr = clr_q;
        valid_wdata = '0;
        clr_d       = clr_q + RA_W'(1);
      end
      S_IDLE: begin
        if (start_i) begin
          cpu_d       = cpu_in;
          irq_d       = irq_number_i;
          dev_d       = device_tag_i;
          now_d       = timestamp_ns_i;
          top_d       = top_in;
          slot_i_d    = '0;
          run_res_d   = '0;
          total_res_d = '0;
          count_res_d = '0;
          priority if (irq_bad) begin
            status_d = ST_IRQ_RANGE;
          end else if (kind_i == KIND_ENTRY) begin
            if (top_in >= TOP_W'(STACK_DEPTH)) begin
              status_d = ST_FULL;
            end else begin
              status_d = ST_ENTRY;
            end
          end else if (top_in == '0) begin
            status_d = ST_EMPTY;
          end else begin
            status_d = ST_EXIT;
          end
        end
      end
      S_PRD: begin
        // The parent of the new frame is the current top frame.
        frame_re = 1'b1;
      end
      S_PSUB: begin
        alu_op = ALU_SUB;
        alu_a  = now_q;
        alu_b  = start_rdata;
        run_d  = alu_y;
      end
      S_PADD: begin
        alu_op      = ALU_ADD;
        alu_a       = accum_rdata;
        alu_b       = run_q;
        accum_we    = 1'b1;
        accum_waddr = f_top;
        accum_wdata = alu_y;
      end
      S_PUSH: begin
        fid_we      = 1'b1;
        start_we    = 1'b1;
        start_waddr = f_new;
        accum_we    = 1'b1;
        accum_waddr = f_new;
        accum_wdata = '0;
        stack_top_d[cpu_q] = top_q + TOP_W'(1);
      end
      S_FRD: begin
        fid_re   = 1'b1;
        frame_re = 1'b1;
        valid_re = 1'b1;
      end
      S_FSUB: begin
        alu_op = ALU_SUB;
        alu_a  = now_q;
        alu_b  = start_rdata;
        if (fid_rd.irq != irq_q) begin
          // Mismatch: drop the top frame without recording it.
          stack_top_d[cpu_q] = top_q - TOP_W'(1);
          status_d           = ST_MISMATCH;
        end else begin
          run_d     = alu_y;
          run_res_d = alu_y;
        end
      end
      S_FADD: begin
        alu_op = ALU_ADD;
        alu_a  = accum_rdata;
        alu_b  = run_q;
        excl_d = alu_y;
      end
      S_WALK: begin
        priority if (walk_end) begin
          status_d = ST_TABLE_FULL;
        end else if (!valid_rdata[slot_sel]) begin
          // First free slot: claim it for this device.
          slot_we               = 1'b1;
          valid_we              = 1'b1;
          valid_wdata           = valid_rdata;
          valid_wdata[slot_sel] = 1'b1;
          status_d              = ST_EXIT;
          total_res_d           = excl_q;
          count_res_d           = COUNT_W'(1);
        end else begin
          slot_re = 1'b1;
        end
      end
      S_CMP: begin
        alu_op = ALU_ADD;
        alu_a  = slot_rd.total;
        alu_b  = excl_q;
        if (slot_rd.device == fid_rd.device) begin
          slot_we     = 1'b1;
          slot_wdata  = '{device: slot_rd.device, total: alu_y, count: count_next};
          status_d    = ST_EXIT;
          total_res_d = alu_y;
          count_res_d = count_next;
        end else begin
          slot_i_d = slot_i_q + SI_W'(1);
        end
      end
      S_POP: begin
        // Resume the parent's clock, then drop the finished frame.
        if (top_q > TOP_W'(1)) begin
          start_we    = 1'b1;
          start_waddr = f_parent;
          start_wdata = now_q;
        end
        stack_top_d[cpu_q] = top_q - TOP_W'(1);
      end
      S_RESP: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      clr_q    <= '0;
      slot_i_q <= '0;
      for (int c = 0; c < CPU_COUNT; c++) begin
        stack_top_q[c] <= '0;
      end
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      slot_i_q    <= slot_i_d;
      stack_top_q <= stack_top_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cpu_q       <= cpu_d;
    irq_q       <= irq_d;
    dev_q       <= dev_d;
    now_q       <= now_d;
    top_q       <= top_d;
    run_q       <= run_d;
    excl_q      <= excl_d;
    status_q    <= status_d;
    run_res_q   <= run_res_d;
    total_res_q <= total_res_d;
    count_res_q <= count_res_d;
  end

  assign busy_o          = state_q != S_IDLE;
  assign done_o          = state_q == S_RESP;
  assign status_o        = status_q;
  assign irq_out_o       = irq_q;
  assign last_run_time_o = run_res_q;
  assign slot_total_o    = total_res_q;
  assign event_count_o   = count_res_q;

`ifndef SYNTHESIS
  // A transfer always starts work, so the block reports busy right after it.
  assert property (@(posedge clk_i) disable iff (!rst_ni) accept |=> busy_o)
    else $error("busy_o low after a transfer");

  // A recorded exit always comes with a nonzero run count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_EXIT) |-> (event_count_o != '0))
    else $error("recorded exit with zero count");

  // Only exits that reach the table report a run time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ST_EXIT && status_o != ST_TABLE_FULL)
      |-> (last_run_time_o == '0 && slot_total_o == '0 && event_count_o == '0))
    else $error("nonzero times on a result without a slot update");

  // A slot search never starts past the last slot of the row.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP) |-> (slot_i_q < SI_W'(SLOTS_PER_IRQ)))
    else $error("slot compare beyond the row");
`endif

endmodule

>>> rtl/nitp_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module nitp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/nitp_alu.sv
// ----------------------------------------------------------------------------
// Shared time arithmetic unit
// One 64-bit adder that adds or subtracts, wrapping modulo 2^64.
// ----------------------------------------------------------------------------
module nitp_alu (
  input  nitp_pkg::alu_op_e          op_i,
  input  logic [nitp_pkg::TIME_W-1:0] a_i,
  input  logic [nitp_pkg::TIME_W-1:0] b_i,
  output logic [nitp_pkg::TIME_W-1:0] y_o
);
  import nitp_pkg::*;

  logic [TIME_W-1:0] b_op;
  logic              carry_in;

  always_comb begin
    unique case (op_i)
      ALU_ADD: begin
        b_op     = b_i;
        carry_in = 1'b0;
      end
      ALU_SUB: begin
        b_op     = ~b_i;
        carry_in = 1'b1;
      end
      default: begin
        b_op     = b_i;
        carry_in = 1'b0;
      end
    endcase
  end

  // Subtraction is a + ~b + 1 through the same adder.
  assign y_o = a_i + b_op + TIME_W'(carry_in);

endmodule

>>> tb/sv/nitp_profile_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Nested IRQ profile checker
// Watches the event and result channels of the profiler, keeps its own copy
// of the nesting stacks and slot table, and compares every result in order.
// ----------------------------------------------------------------------------
module nitp_profile_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic                         busy_i,
  input  logic                         kind_i,
  input  logic [1:0]                   cpu_index_i,
  input  logic [nitp_pkg::IRQ_W-1:0]   irq_number_i,
  input  logic [nitp_pkg::DEV_W-1:0]   device_tag_i,
  input  logic [nitp_pkg::TIME_W-1:0]  timestamp_ns_i,
  input  logic                         done_i,
  input  logic [2:0]                   status_i,
  input  logic [nitp_pkg::IRQ_W-1:0]   irq_out_i,
  input  logic [nitp_pkg::TIME_W-1:0]  last_run_time_i,
  input  logic [nitp_pkg::TIME_W-1:0]  slot_total_i,
  input  logic [nitp_pkg::COUNT_W-1:0] event_count_i,
  output int                           pending_o,
  output int                           errors_o,
  output int                           checked_o,
  output logic [6:0]                   status_seen_o
);
  import nitp_pkg::*;

  typedef struct {
    status_e            status;
    logic [IRQ_W-1:0]   irq;
    logic [TIME_W-1:0]  run;
    logic [TIME_W-1:0]  total;
    logic [COUNT_W-1:0] count;
  } profile_result_t;

  profile_result_t    awaited_results[$];

  int                 nest_depth[CPU_COUNT];
  logic [IRQ_W-1:0]   fr_irq[FRAMES];
  logic [DEV_W-1:0]   fr_dev[FRAMES];
  logic [TIME_W-1:0]  fr_start[FRAMES];
  logic [TIME_W-1:0]  fr_accum[FRAMES];
  bit                 slot_used[SLOTS_ALL];
  logic [DEV_W-1:0]   slot_dev[SLOTS_ALL];
  logic [TIME_W-1:0]  slot_total[SLOTS_ALL];
  logic [COUNT_W-1:0] slot_runs[SLOTS_ALL];

  int                 err_count;
  int                 checked;
  logic [6:0]         seen;

  // Applies one accepted event to the stacks and table and queues the result
  // that the block must give for it.
  task automatic profile_event(input logic kind, input logic [1:0] cpu,
                               input logic [IRQ_W-1:0] irq,
                               input logic [DEV_W-1:0] dev,
                               input logic [TIME_W-1:0] now);
    profile_result_t   r;
    int                depth;
    int                base;
    int                fr;
    int                sb;
    int                hit;
    int                i;
    logic [TIME_W-1:0] run;
    logic [TIME_W-1:0] excl;
    r.status = ST_ENTRY;
    r.irq    = irq;
    r.run    = '0;
    r.total  = '0;
    r.count  = '0;
    depth    = nest_depth[cpu];
    base     = cpu * STACK_DEPTH;
    if (irq >= IRQ_COUNT) begin
      r.status = ST_IRQ_RANGE;
    end else if (kind == KIND_ENTRY) begin
      if (depth >= STACK_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        // The interrupted parent is charged for the time it ran so far.
        if (depth > 0) begin
          fr_accum[base + depth - 1] += now - fr_start[base + depth - 1];
        end
        fr_irq[base + depth]   = irq;
        fr_dev[base + depth]   = dev;
        fr_start[base + depth] = now;
        fr_accum[base + depth] = '0;
        nest_depth[cpu]        = depth + 1;
      end
    end else if (depth == 0) begin
      r.status = ST_EMPTY;
    end else begin
      fr   = base + depth - 1;
      run  = now - fr_start[fr];
      excl = fr_accum[fr] + run;
      if (fr_irq[fr] != irq) begin
        // A mismatched exit drops the frame and leaves the parent paused.
        nest_depth[cpu] = depth - 1;
        r.status        = ST_MISMATCH;
      end else begin
        hit = -1;
        sb  = (cpu * IRQ_COUNT + int'(irq)) * SLOTS_PER_IRQ;
        for (i = 0; i < SLOTS_PER_IRQ; i++) begin
          if (hit < 0) begin
            if (slot_used[sb + i] && slot_dev[sb + i] == fr_dev[fr]) begin
              if (slot_runs[sb + i] != '1) slot_runs[sb + i]++;
              slot_total[sb + i] += excl;
              hit = sb + i;
            end else if (!slot_used[sb + i]) begin
              slot_used[sb + i]  = 1'b1;
              slot_dev[sb + i]   = fr_dev[fr];
              slot_total[sb + i] = excl;
              slot_runs[sb + i]  = 1;
              hit = sb + i;
            end
          end
        end
        if (depth > 1) fr_start[fr - 1] = now;
        nest_depth[cpu] = depth - 1;
        r.run = run;
        if (hit < 0) begin
          r.status = ST_TABLE_FULL;
        end else begin
          r.status = ST_EXIT;
          r.total  = slot_total[hit];
          r.count  = slot_runs[hit];
        end
      end
    end
    awaited_results.push_back(r);
  endtask

  task automatic report_field(input string name, input logic [TIME_W-1:0] want,
                              input logic [TIME_W-1:0] got);
    err_count++;
    $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
  endtask

  task automatic check_result();
    profile_result_t want;
    if (awaited_results.size() == 0) begin
      err_count++;
      $display("%0t: result with status %0d irq %0h arrived with nothing awaited",
               $time, status_i, irq_out_i);
    end else begin
      want = awaited_results.pop_front();
      if (status_i !== want.status)        report_field("status", want.status, status_i);
      if (irq_out_i !== want.irq)          report_field("irq_out", want.irq, irq_out_i);
      if (last_run_time_i !== want.run)    report_field("last_run_time", want.run,
                                                        last_run_time_i);
      if (slot_total_i !== want.total)     report_field("slot_total", want.total,
                                                        slot_total_i);
      if (event_count_i !== want.count)    report_field("event_count", want.count,
                                                        event_count_i);
      checked++;
      if (!$isunknown(status_i) && status_i < 3'd7) seen[status_i] = 1'b1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awaited_results.delete();
      foreach (nest_depth[c]) nest_depth[c] = 0;
      foreach (slot_used[s]) slot_used[s] = 1'b0;
      err_count     = 0;
      checked       = 0;
      seen          = '0;
      pending_o     <= 0;
      errors_o      <= 0;
      checked_o     <= 0;
      status_seen_o <= '0;
    end else begin
      if (done_i) check_result();
      if (start_i && !busy_i) begin
        profile_event(kind_i, cpu_index_i, irq_number_i, device_tag_i, timestamp_ns_i);
      end
      pending_o     <= awaited_results.size();
      errors_o      <= err_count;
      checked_o     <= checked;
      status_seen_o <= seen;
    end
  end

endmodule

>>> tb/sv/nested_irq_time_profiler_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Nested IRQ time profiler testbench
// Drives interrupt entry and exit events into the profiler, first a directed
// set of corner cases and then three random phases with different sender
// gaps, while a checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module nested_irq_time_profiler_unit_tb;
  import nitp_pkg::*;

  logic               clk_i;
  logic               rst_ni         = 1'b0;
  logic               start_i        = 1'b0;
  logic               kind_i         = KIND_ENTRY;
  logic [1:0]         cpu_index_i    = '0;
  logic [IRQ_W-1:0]   irq_number_i   = '0;
  logic [DEV_W-1:0]   device_tag_i   = '0;
  logic [TIME_W-1:0]  timestamp_ns_i = '0;
  logic               busy_o;
  logic               done_o;
  logic [2:0]         status_o;
  logic [IRQ_W-1:0]   irq_out_o;
  logic [TIME_W-1:0]  last_run_time_o;
  logic [TIME_W-1:0]  slot_total_o;
  logic [COUNT_W-1:0] event_count_o;

  int                 pending;
  int                 errors;
  int                 checked;
  logic [6:0]         status_seen;

  // Sender bookkeeping. This only shapes the stimulus: it tracks which IRQ is
  // open at the top of each CPU's stack so that most exits are well formed.
  int                 idle_pct;
  int                 sent_count;
  int                 open_depth[CPU_COUNT];
  int                 target_depth[CPU_COUNT];
  logic [IRQ_W-1:0]   open_irq[CPU_COUNT][STACK_DEPTH];
  logic [TIME_W-1:0]  cpu_clock[CPU_COUNT];
  logic [DEV_W-1:0]   tag_pool[6];

  nested_irq_time_profiler_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .kind_i          (kind_i),
    .cpu_index_i     (cpu_index_i),
    .irq_number_i    (irq_number_i),
    .device_tag_i    (device_tag_i),
    .timestamp_ns_i  (timestamp_ns_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .irq_out_o       (irq_out_o),
    .last_run_time_o (last_run_time_o),
    .slot_total_o    (slot_total_o),
    .event_count_o   (event_count_o)
  );

  nitp_profile_checker checker_inst (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_i          (busy_o),
    .kind_i          (kind_i),
    .cpu_index_i     (cpu_index_i),
    .irq_number_i    (irq_number_i),
    .device_tag_i    (device_tag_i),
    .timestamp_ns_i  (timestamp_ns_i),
    .done_i          (done_o),
    .status_i        (status_o),
    .irq_out_i       (irq_out_o),
    .last_run_time_i (last_run_time_o),
    .slot_total_i    (slot_total_o),
    .event_count_i   (event_count_o),
    .pending_o       (pending),
    .errors_o        (errors),
    .checked_o       (checked),
    .status_seen_o   (status_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hard stop. The slowest legal run (the clearing pass, about 1800 events and
  // sender gaps) stays far below this.
  initial begin
    #5ms;
    $display("Timeout: events still outstanding or the block stopped responding.");
    $display("nested_irq_time_profiler_unit_tb: errors");
    $finish;
  end

  // Presents one event and returns at the falling edge right after its
  // transfer. Inputs only move on falling edges, and busy_o only moves on
  // rising edges, so busy_o seen low here means the next rising edge takes
  // the event. With a gap, start_i drops low first, so a gap
  // can land on any phase of the block's work on the previous event.
  task automatic send_event(input logic k, input logic [1:0] c,
                            input logic [IRQ_W-1:0] q, input logic [DEV_W-1:0] d,
                            input logic [TIME_W-1:0] t);
    if ($urandom_range(0, 99) < idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    start_i        <= 1'b1;
    kind_i         <= k;
    cpu_index_i    <= c;
    irq_number_i   <= q;
    device_tag_i   <= d;
    timestamp_ns_i <= t;
    while (busy_o) @(negedge clk_i);
    @(negedge clk_i);
    sent_count++;
    // Mirror the stack movement so later exits can name the open IRQ.
    if (q < IRQ_COUNT) begin
      if (k == KIND_ENTRY) begin
        if (open_depth[c] < STACK_DEPTH) begin
          open_irq[c][open_depth[c]] = q;
          open_depth[c]++;
        end
      end else if (open_depth[c] > 0) begin
        open_depth[c]--;
      end
    end
  endtask

  // Holds the sender off until every result owed by the block has come.
  // At least one falling edge passes, so start_i never gets two updates in
  // one time step.
  task automatic drain_results();
    start_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  // Most IRQs come from a small hot set so that slots fill up and the table
  // runs out for some (CPU, IRQ) rows; the rest spread over the full range.
  function automatic logic [IRQ_W-1:0] pick_irq();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return IRQ_W'(IRQ_COUNT - 1);
    if (r < 8) return IRQ_W'($urandom_range(1, 5));
    return IRQ_W'($urandom_range(0, IRQ_COUNT - 1));
  endfunction

  // Time step between events on one CPU: mostly short handlers, sometimes
  // long gaps, and now and then a jump large enough to wrap the clock.
  function automatic logic [TIME_W-1:0] advance_time();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 2) return {$urandom, $urandom};
    if (r < 12) return TIME_W'($urandom);
    return TIME_W'($urandom_range(1, 2000));
  endfunction

  // Directed corners: exit on an empty stack, out-of-range IRQs at both
  // ends, a stack pushed to its full depth across a clock wrap, an entry
  // refused on the full stack, a normal exit from the full stack, and an
  // exit whose IRQ does not match the top frame.
  task automatic run_directed();
    logic [TIME_W-1:0] t;
    int                i;
    send_event(KIND_EXIT, 2'd0, IRQ_W'(5), DEV_W'(0), TIME_W'(100));
    send_event(KIND_ENTRY, 2'd1, IRQ_W'(IRQ_COUNT), '1, '1);
    send_event(KIND_EXIT, 2'd2, '1, '0, '0);
    t = 64'hFFFF_FFFF_FFFF_FF00;
    for (i = 0; i < STACK_DEPTH; i++) begin
      send_event(KIND_ENTRY, 2'd3,
                 (i == 0) ? IRQ_W'(0) :
                 (i == STACK_DEPTH - 1) ? IRQ_W'(IRQ_COUNT - 1) : IRQ_W'(i * 31),
                 (i % 2 == 1) ? '1 : DEV_W'(i), t);
      t += 37;
    end
    send_event(KIND_ENTRY, 2'd3, IRQ_W'(7), DEV_W'(7), t);
    t += 1000;
    send_event(KIND_EXIT, 2'd3, IRQ_W'(IRQ_COUNT - 1), $urandom, t);
    t += 250;
    send_event(KIND_EXIT, 2'd3, IRQ_W'(99), $urandom, t);
    cpu_clock[3] = t;
  endtask

  // One random event. Most events follow each CPU's stack: entries climb
  // toward a random target depth, exits name the open IRQ, so frames nest
  // deeply and parents are charged and resumed. A small share is noise:
  // wrong IRQs on exit, arbitrary timestamps, and out-of-range IRQs.
  task automatic random_event();
    int unsigned       r;
    logic [1:0]        c;
    logic              k;
    logic [IRQ_W-1:0]  q;
    logic [DEV_W-1:0]  d;
    logic [TIME_W-1:0] t;
    r = $urandom_range(0, 99);
    c = 2'($urandom_range(0, CPU_COUNT - 1));
    d = tag_pool[$urandom_range(0, 5)];
    if ($urandom_range(0, 9) == 0) d = $urandom;
    cpu_clock[c] += advance_time();
    t = cpu_clock[c];
    if (r < 5) begin
      k = 1'($urandom_range(0, 1));
      q = IRQ_W'($urandom_range(IRQ_COUNT, 65535));
    end else if (r < 10) begin
      k = 1'($urandom_range(0, 1));
      q = pick_irq();
      t = {$urandom, $urandom};
    end else begin
      if (open_depth[c] == target_depth[c]) begin
        target_depth[c] = $urandom_range(0, STACK_DEPTH);
      end
      // A full stack now and then sees one more entry, which is refused.
      if (open_depth[c] < target_depth[c] ||
          (open_depth[c] == STACK_DEPTH && $urandom_range(0, 4) == 0)) begin
        k = KIND_ENTRY;
        q = pick_irq();
      end else begin
        k = KIND_EXIT;
        if (open_depth[c] > 0 && $urandom_range(0, 99) >= 4) begin
          q = open_irq[c][open_depth[c] - 1];
        end else begin
          q = pick_irq();
        end
      end
    end
    send_event(k, c, q, d, t);
  endtask

  initial begin
    int n;
    int phase;
    idle_pct   = 19;
    sent_count = 0;
    foreach (open_depth[c]) begin
      open_depth[c]   = 0;
      target_depth[c] = 0;
      cpu_clock[c]    = {$urandom, $urandom};
    end
    // One CPU starts just below the top of the time range so that its
    // handlers straddle the wrap early on.
    cpu_clock[2] = '1 - 64'd5000;
    tag_pool[0]  = '0;
    tag_pool[1]  = '1;
    for (n = 2; n < 6; n++) tag_pool[n] = $urandom;

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    run_directed();
    // Sender pauses here until every directed result has been checked.
    drain_results();

    // Three random phases: sender gaps at 19 percent, then at 72 percent,
    // then back to back. The receiver side cannot stall, so only the sender
    // pattern changes.
    for (phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 19 : (phase == 1) ? 72 : 0;
      for (n = 0; n < 600; n++) random_event();
      drain_results();
    end

    // Allow the longest exit latency to pass so a stray late result shows.
    repeat (20) @(negedge clk_i);

    $display("Sent %0d events (directed corners, then gaps of 19%%, 72%% and none);",
             sent_count);
    $display("%0d results checked, statuses seen from table full down to entry: %b",
             checked, status_seen);
    if (errors == 0 && pending == 0) begin
      $display("nested_irq_time_profiler_unit_tb: clean");
    end else begin
      $display("%0d mismatches, %0d results still outstanding.", errors, pending);
      $display("nested_irq_time_profiler_unit_tb: errors");
    end
    $finish;
  end

endmodule
